/* sv/dda_pkg.sv */
`default_nettype none

package dda_pkg;

	// default width of the running sum
	localparam int SUM_WIDTH_DEF = 32;

	// token counter width and its saturation point
	localparam int CNT_W = 17;
	localparam logic [CNT_W-1:0] COUNT_SAT = 17'h1FFFE;

	// separator after reset is a comma
	localparam logic [7:0] SEP_RESET = 8'd44;

	// operations issued by the sequencer to the token unit
	typedef enum logic [2:0] {
		OP_NONE,
		OP_CHAR,
		OP_SCALE,
		OP_ADD,
		OP_RESET
	} op_t;

	// command from the sequencer to the token unit
	typedef struct packed {
		op_t        op;
		logic [7:0] chr;
		logic       inc_count;
	} cmd_t;

endpackage

`default_nettype wire

/* sv/delimited_decimal_average.sv */
// per byte: ST_CHAR before ready again; a separator byte also passes ST_SCALE and ST_ADD
// last byte: result via ST_SCALE, ST_ADD, ST_DIV_GO, ST_DIV_WAIT, ST_OUT; the average comes
// from a bit-serial divider that takes one quotient bit per cycle
// one string at a time; ready only in ST_IDLE: input stalls per byte and on a full output
// reset: asynchronous, active low; clears the parse state, sum, count and overflow,
// and sets the separator to a comma
`default_nettype none

module delimited_decimal_average #(
	parameter int SUM_WIDTH = dda_pkg::SUM_WIDTH_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// separator write
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [7:0]  cfg_data,
	// input bytes
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [7:0]  s_tdata,   // data_byte
	input  wire logic        s_tlast,   // last_byte
	input  wire logic        s_tuser,   // empty_string
	// results
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [87:0]      m_tdata,   // average_hundredths, token_sum, token_count, zero pad
	output logic             m_tuser    // overflow
);

	localparam int EXT_W = SUM_WIDTH + 32;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CHAR,
		ST_SCALE,
		ST_ADD,
		ST_DIV_GO,
		ST_DIV_WAIT,
		ST_OUT
	} state_t;

	state_t                    state_q;
	logic [7:0]                sep_q;
	logic [7:0]                chr_q;
	logic                      last_q;
	logic                      empty_q;
	logic                      end_q;
	logic                      inc_q;
	logic                      m_valid_q;
	logic [31:0]               avg_q;
	logic [31:0]               sum_out_q;
	logic [dda_pkg::CNT_W-1:0] cnt_out_q;
	logic                      ovf_out_q;

	dda_pkg::cmd_t             cmd;
	logic [SUM_WIDTH-1:0]      tok_sum;
	logic [dda_pkg::CNT_W-1:0] tok_count;
	logic                      tok_ovf;
	logic [dda_pkg::CNT_W-1:0] divisor;
	logic                      div_done;
	logic [31:0]               div_quot;
	logic                      is_sep;
	logic                      out_free;
	logic [EXT_W-1:0]          sum_ext;

	assign is_sep   = chr_q == sep_q;
	assign out_free = !m_valid_q || m_tready;
	assign divisor  = tok_count + 1'b1;
	assign sum_ext  = EXT_W'(tok_sum);

	// command to the token unit
	always_comb begin
		cmd.chr       = chr_q;
		cmd.inc_count = inc_q;
		unique case (state_q)
			ST_CHAR:  cmd.op = (!empty_q && !is_sep) ? dda_pkg::OP_CHAR : dda_pkg::OP_NONE;
			ST_SCALE: cmd.op = dda_pkg::OP_SCALE;
			ST_ADD:   cmd.op = dda_pkg::OP_ADD;
			ST_OUT:   cmd.op = out_free ? dda_pkg::OP_RESET : dda_pkg::OP_NONE;
			default:  cmd.op = dda_pkg::OP_NONE;
		endcase
	end

	dda_token #(
		.SUM_WIDTH (SUM_WIDTH)
	) u_token (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.sum    (tok_sum),
		.count  (tok_count),
		.ovf    (tok_ovf)
	);

	dda_divider #(
		.SUM_WIDTH (SUM_WIDTH)
	) u_divider (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (state_q == ST_DIV_GO),
		.dividend (tok_sum),
		.divisor  (divisor),
		.done     (div_done),
		.quotient (div_quot)
	);

	// separator register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sep_q <= dda_pkg::SEP_RESET;
		end else if (cfg_valid) begin
			sep_q <= cfg_data;
		end
	end

	assign cfg_ready = 1'b1;

	// sequencer and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			chr_q     <= '0;
			last_q    <= 1'b0;
			empty_q   <= 1'b0;
			end_q     <= 1'b0;
			inc_q     <= 1'b0;
			m_valid_q <= 1'b0;
			avg_q     <= '0;
			sum_out_q <= '0;
			cnt_out_q <= '0;
			ovf_out_q <= 1'b0;
		end else begin
			// output transaction taken and no new result loaded this cycle
			if (m_valid_q && m_tready && (state_q != ST_OUT)) begin
				m_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (s_tvalid) begin
						chr_q   <= s_tdata;
						last_q  <= s_tlast;
						empty_q <= s_tuser;
						state_q <= ST_CHAR;
					end
				end
				ST_CHAR: begin
					if (empty_q) begin
						end_q   <= 1'b1;
						inc_q   <= 1'b0;
						state_q <= ST_SCALE;
					end else if (is_sep) begin
						end_q   <= last_q;
						inc_q   <= 1'b1;
						state_q <= ST_SCALE;
					end else if (last_q) begin
						end_q   <= 1'b1;
						inc_q   <= 1'b0;
						state_q <= ST_SCALE;
					end else begin
						state_q <= ST_IDLE;
					end
				end
				ST_SCALE: begin
					state_q <= ST_ADD;
				end
				ST_ADD: begin
					inc_q   <= 1'b0;
					state_q <= end_q ? ST_DIV_GO : ST_IDLE;
				end
				ST_DIV_GO: begin
					state_q <= ST_DIV_WAIT;
				end
				ST_DIV_WAIT: begin
					if (div_done) begin
						state_q <= ST_OUT;
					end
				end
				ST_OUT: begin
					if (out_free) begin
						m_valid_q <= 1'b1;
						avg_q     <= div_quot;
						sum_out_q <= sum_ext[31:0];
						cnt_out_q <= divisor;
						ovf_out_q <= tok_ovf;
						end_q     <= 1'b0;
						state_q   <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign s_tready = state_q == ST_IDLE;
	assign m_tvalid = m_valid_q;
	assign m_tdata  = {7'd0, cnt_out_q, sum_out_q, avg_q};
	assign m_tuser  = ovf_out_q;

endmodule

`default_nettype wire

/* sv/dda_token.sv */
`default_nettype none

module dda_token #(
	parameter int SUM_WIDTH = dda_pkg::SUM_WIDTH_DEF
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire dda_pkg::cmd_t              cmd,
	output logic [SUM_WIDTH-1:0]            sum,
	output logic [dda_pkg::CNT_W-1:0]       count,
	output logic                            ovf
);

	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_POINT = 8'h2E;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_FIVE  = 8'h35;
	localparam logic [7:0] CH_NINE  = 8'h39;
	localparam int         EXT_W    = SUM_WIDTH + 32;
	// bound on the token magnitude from the sum width, all ones when the sum is wider
	localparam logic [32:0] SW_LIM  = (SUM_WIDTH >= 33) ? {33{1'b1}} :
		(33'd1 << (SUM_WIDTH - 1));

	typedef enum logic [1:0] {
		PH_START,
		PH_INT,
		PH_FRAC,
		PH_SKIP
	} phase_t;

	phase_t                    phase_q, phase_d;
	logic                      neg_q, neg_d;
	logic [31:0]               mag_q;
	logic [1:0]                fds_q, fds_d;
	logic [SUM_WIDTH-1:0]      sum_q;
	logic [dda_pkg::CNT_W-1:0] count_q;
	logic                      ovf_q;

	logic                      digit;
	logic [3:0]                dval;
	logic                      scale_en;
	logic [6:0]                scale_mul;
	logic                      mac_en;
	logic [6:0]                mac_mul;
	logic [3:0]                mac_add;
	logic [39:0]               mac_r;
	logic                      mac_ovf;
	logic                      fit32;
	logic                      fitsw;
	logic [EXT_W-1:0]          mag_ext;
	logic [EXT_W-1:0]          val_ext;
	logic [SUM_WIDTH-1:0]      add_b;
	logic [SUM_WIDTH-1:0]      add_r;
	logic                      add_ovf;

	// character classes
	assign digit = (cmd.chr >= CH_ZERO) && (cmd.chr <= CH_NINE);
	assign dval  = digit ? 4'(cmd.chr - CH_ZERO) : 4'd0;

	// pending scale of the token to hundredths
	assign scale_en  = (phase_q == PH_START) || (phase_q == PH_INT) ||
		((phase_q == PH_FRAC) && (fds_q != 2'd2));
	assign scale_mul = ((phase_q == PH_FRAC) && (fds_q == 2'd1)) ? 7'd10 : 7'd100;

	// parse step: next token state and multiply-add request
	always_comb begin
		phase_d = phase_q;
		neg_d   = neg_q;
		fds_d   = fds_q;
		mac_en  = 1'b0;
		mac_mul = 7'd0;
		mac_add = 4'd0;
		unique case (cmd.op)
			dda_pkg::OP_CHAR: begin
				unique case (phase_q)
					PH_START: begin
						if (cmd.chr == CH_MINUS) begin
							neg_d   = 1'b1;
							phase_d = PH_INT;
						end else if (cmd.chr == CH_PLUS) begin
							phase_d = PH_INT;
						end else if (digit) begin
							mac_en  = 1'b1;
							mac_mul = 7'd1;
							mac_add = dval;
							phase_d = PH_INT;
						end else if (cmd.chr == CH_POINT) begin
							phase_d = PH_FRAC;
							fds_d   = 2'd0;
						end else begin
							mac_en  = scale_en;
							mac_mul = scale_mul;
							phase_d = PH_SKIP;
						end
					end
					PH_INT: begin
						if (digit) begin
							mac_en  = 1'b1;
							mac_mul = 7'd10;
							mac_add = dval;
						end else if (cmd.chr == CH_POINT) begin
							phase_d = PH_FRAC;
							fds_d   = 2'd0;
						end else begin
							mac_en  = scale_en;
							mac_mul = scale_mul;
							phase_d = PH_SKIP;
						end
					end
					PH_FRAC: begin
						if (fds_q == 2'd2) begin
							// rounding digit
							if ((cmd.chr >= CH_FIVE) && (cmd.chr <= CH_NINE)) begin
								mac_en  = 1'b1;
								mac_mul = 7'd1;
								mac_add = 4'd1;
							end
							phase_d = PH_SKIP;
						end else if (digit) begin
							mac_en  = 1'b1;
							mac_mul = 7'd10;
							mac_add = dval;
							fds_d   = fds_q + 2'd1;
						end else begin
							mac_en  = scale_en;
							mac_mul = scale_mul;
							phase_d = PH_SKIP;
						end
					end
					PH_SKIP: begin
					end
					default: begin
					end
				endcase
			end
			dda_pkg::OP_SCALE: begin
				mac_en  = scale_en;
				mac_mul = scale_mul;
				phase_d = PH_SKIP;
			end
			default: begin
			end
		endcase
	end

	// shared multiply-add on the token magnitude
	assign mac_r   = 40'(mag_q) * 40'(mac_mul) + 40'(mac_add);
	assign mac_ovf = mac_r > 40'h0080000000;

	// token value range checks
	assign fit32 = neg_q ? (mag_q <= 32'h80000000) : !mag_q[31];
	assign fitsw = neg_q ? ({1'b0, mag_q} <= SW_LIM) : ({1'b0, mag_q} < SW_LIM);

	// signed add of the token into the running sum
	assign mag_ext = EXT_W'(mag_q);
	assign val_ext = neg_q ? (-mag_ext) : mag_ext;
	assign add_b   = val_ext[SUM_WIDTH-1:0];
	assign add_r   = sum_q + add_b;
	assign add_ovf = (sum_q[SUM_WIDTH-1] == add_b[SUM_WIDTH-1]) &&
		(add_r[SUM_WIDTH-1] != sum_q[SUM_WIDTH-1]);

	// token and string state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_START;
			neg_q   <= 1'b0;
			mag_q   <= '0;
			fds_q   <= 2'd0;
			sum_q   <= '0;
			count_q <= '0;
			ovf_q   <= 1'b0;
		end else begin
			unique case (cmd.op)
				dda_pkg::OP_CHAR, dda_pkg::OP_SCALE: begin
					phase_q <= phase_d;
					neg_q   <= neg_d;
					fds_q   <= fds_d;
					if (mac_en) begin
						mag_q <= mac_r[31:0];
						if (mac_ovf) begin
							ovf_q <= 1'b1;
						end
					end
				end
				dda_pkg::OP_ADD: begin
					sum_q <= add_r;
					if (!fit32 || !fitsw || add_ovf) begin
						ovf_q <= 1'b1;
					end
					if (cmd.inc_count && (count_q < dda_pkg::COUNT_SAT)) begin
						count_q <= count_q + 1'b1;
					end
					phase_q <= PH_START;
					neg_q   <= 1'b0;
					mag_q   <= '0;
					fds_q   <= 2'd0;
				end
				dda_pkg::OP_RESET: begin
					phase_q <= PH_START;
					neg_q   <= 1'b0;
					mag_q   <= '0;
					fds_q   <= 2'd0;
					sum_q   <= '0;
					count_q <= '0;
					ovf_q   <= 1'b0;
				end
				default: begin
				end
			endcase
		end
	end

	assign sum   = sum_q;
	assign count = count_q;
	assign ovf   = ovf_q;

endmodule

`default_nettype wire

/* sv/dda_divider.sv */
`default_nettype none

module dda_divider #(
	parameter int SUM_WIDTH = dda_pkg::SUM_WIDTH_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          start,
	input  wire logic [SUM_WIDTH-1:0]          dividend,
	input  wire logic [dda_pkg::CNT_W-1:0]     divisor,
	output logic                               done,
	output logic [31:0]                        quotient
);

	localparam int CW    = $clog2(SUM_WIDTH + 1);
	localparam int EXT_W = SUM_WIDTH + 32;

	logic                      busy_q;
	logic                      done_q;
	logic [CW-1:0]             cnt_q;
	logic                      neg_q;
	logic [SUM_WIDTH-1:0]      num_q;
	logic [dda_pkg::CNT_W-1:0] div_q;
	logic [dda_pkg::CNT_W-1:0] rem_q;

	logic [dda_pkg::CNT_W:0]   rem_sh;
	logic                      take;
	logic [dda_pkg::CNT_W:0]   rem_sub;
	logic [EXT_W-1:0]          q_ext;
	logic [EXT_W-1:0]          q_signed;

	// one restoring step per cycle on the magnitude
	assign rem_sh  = {rem_q, num_q[SUM_WIDTH-1]};
	assign take    = rem_sh >= {1'b0, div_q};
	assign rem_sub = rem_sh - {1'b0, div_q};

	// sequencer and datapath registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
			neg_q  <= 1'b0;
			num_q  <= '0;
			div_q  <= '0;
			rem_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(SUM_WIDTH);
				neg_q  <= dividend[SUM_WIDTH-1];
				num_q  <= dividend[SUM_WIDTH-1] ? (-dividend) : dividend;
				div_q  <= divisor;
				rem_q  <= '0;
			end else if (busy_q) begin
				rem_q  <= take ? rem_sub[dda_pkg::CNT_W-1:0] : rem_sh[dda_pkg::CNT_W-1:0];
				num_q  <= {num_q[SUM_WIDTH-2:0], take};
				cnt_q  <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// sign of the quotient, truncated toward zero
	assign q_ext    = EXT_W'(num_q);
	assign q_signed = neg_q ? (-q_ext) : q_ext;
	assign quotient = q_signed[31:0];
	assign done     = done_q;

endmodule

`default_nettype wire
